### hw/rtl/kti_pkg.sv
// Shared types and constants for the keyframe track interpolator.
package kti_pkg;

    localparam int NCOMP     = 9;
    localparam int TIME_W    = 22;
    localparam int COMP_W    = 32;
    localparam int FRAC_W    = 17;
    localparam int K_W       = 4;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_W - 1);
    localparam logic [K_W-1:0]       K_LAST   = K_W'(NCOMP - 1);

    localparam logic       CMD_INSERT = 1'b0;

    localparam logic [1:0] STAT_SAMPLED  = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_INSERTED = 2'd2;
    localparam logic [1:0] STAT_DROPPED  = 2'd3;

    localparam logic [COMP_W-1:0] ONE_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic [TIME_W-1:0]            tm;
        logic [NCOMP-1:0][COMP_W-1:0] comp;
    } key_row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_WR,
        ST_SMP_CHK0,
        ST_SMP_CHKL,
        ST_SMP_CHKN,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_DROP,
        OP_EMPTY,
        OP_INS_RD,
        OP_INS_SHIFT,
        OP_INS_WR,
        OP_RD_FIRST,
        OP_TAKE_ROW,
        OP_RD_LAST,
        OP_RD_IDX,
        OP_NEXT_IDX,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL,
        OP_ADD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic full;
        logic empty;
        logic idx_one;
        logic t_le_rd;
        logic t_ge_rd;
        logic div_last;
        logic comp_last;
    } dp_stat_t;

endpackage

### hw/rtl/keyframe_track_interpolator_top.sv
// An insert shifts each key later than the new time up one slot, then writes the new key.
// An insert into a full track is dropped; a sample of an empty track or one outside the keys is clamped or defaulted.
// An interpolated sample searches forward for the bracket end, divides for the fraction, then blends.
// Interpolation uses a 17-step fraction divider and 9 serial multiply-adds.
// One item at a time; the next item is taken once the result is in the output register.
// rst_n is asynchronous, active low, and empties the track; key storage is not cleared.
module keyframe_track_interpolator_top
    import kti_pkg::*;
#(
    parameter int KEY_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [21:0]        time_value,
    input  logic signed [31:0] key_pos_x,
    input  logic signed [31:0] key_pos_y,
    input  logic signed [31:0] key_pos_z,
    input  logic signed [31:0] key_rot_x,
    input  logic signed [31:0] key_rot_y,
    input  logic signed [31:0] key_rot_z,
    input  logic signed [31:0] key_scale_x,
    input  logic signed [31:0] key_scale_y,
    input  logic signed [31:0] key_scale_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] res_pos_x,
    output logic signed [31:0] res_pos_y,
    output logic signed [31:0] res_pos_z,
    output logic signed [31:0] res_rot_x,
    output logic signed [31:0] res_rot_y,
    output logic signed [31:0] res_rot_z,
    output logic signed [31:0] res_scale_x,
    output logic signed [31:0] res_scale_y,
    output logic signed [31:0] res_scale_z
);

    dp_cmd_t                      dcmd;
    dp_stat_t                     dstat;
    logic [NCOMP-1:0][COMP_W-1:0] in_comp;
    logic [NCOMP-1:0][COMP_W-1:0] res;

    assign in_comp[0] = key_pos_x;
    assign in_comp[1] = key_pos_y;
    assign in_comp[2] = key_pos_z;
    assign in_comp[3] = key_rot_x;
    assign in_comp[4] = key_rot_y;
    assign in_comp[5] = key_rot_z;
    assign in_comp[6] = key_scale_x;
    assign in_comp[7] = key_scale_y;
    assign in_comp[8] = key_scale_z;

    assign res_pos_x   = res[0];
    assign res_pos_y   = res[1];
    assign res_pos_z   = res[2];
    assign res_rot_x   = res[3];
    assign res_rot_y   = res[4];
    assign res_rot_z   = res[5];
    assign res_scale_x = res[6];
    assign res_scale_y = res[7];
    assign res_scale_z = res[8];

    kti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (dstat),
        .cmd       (dcmd)
    );

    kti_dp #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dcmd),
        .st         (dstat),
        .in_cmd     (cmd),
        .in_time    (time_value),
        .in_comp    (in_comp),
        .out_status (status),
        .out_res    (res)
    );

endmodule

### hw/rtl/kti_ctrl.sv
// Sequencer for insert and sample items.
module kti_ctrl
    import kti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t st,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                if (st.is_insert)
                begin
                    if (st.full)       state_next = ST_DONE;
                    else if (st.empty) state_next = ST_INS_WR;
                    else               state_next = ST_INS_RD;
                end
                else if (st.empty) state_next = ST_DONE;
                else               state_next = ST_SMP_CHK0;
            end
            ST_INS_RD:   state_next = ST_INS_CHK;
            ST_INS_CHK:
            begin
                if (!st.t_ge_rd && !st.idx_one) state_next = ST_INS_RD;
                else                            state_next = ST_INS_WR;
            end
            ST_INS_WR:   state_next = ST_DONE;
            ST_SMP_CHK0: state_next = st.t_le_rd ? ST_DONE : ST_SMP_CHKL;
            ST_SMP_CHKL: state_next = st.t_ge_rd ? ST_DONE : ST_SMP_CHKN;
            ST_SMP_CHKN: state_next = st.t_le_rd ? ST_DIV : ST_SMP_CHKN;
            ST_DIV:      if (st.div_last) state_next = ST_MUL;
            ST_MUL:      state_next = ST_ADD;
            ST_ADD:      state_next = st.comp_last ? ST_DONE : ST_MUL;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:     if (in_valid) cmd.op = OP_CAPTURE;
            ST_DISPATCH:
            begin
                if (st.is_insert)
                begin
                    if (st.full) cmd.op = OP_DROP;
                end
                else if (st.empty) cmd.op = OP_EMPTY;
                else               cmd.op = OP_RD_FIRST;
            end
            ST_INS_RD:   cmd.op = OP_INS_RD;
            ST_INS_CHK:  if (!st.t_ge_rd) cmd.op = OP_INS_SHIFT;
            ST_INS_WR:   cmd.op = OP_INS_WR;
            ST_SMP_CHK0: cmd.op = st.t_le_rd ? OP_TAKE_ROW : OP_RD_LAST;
            ST_SMP_CHKL: cmd.op = st.t_ge_rd ? OP_TAKE_ROW : OP_RD_IDX;
            ST_SMP_CHKN: cmd.op = st.t_le_rd ? OP_DIV_INIT : OP_NEXT_IDX;
            ST_DIV:      cmd.op = OP_DIV_STEP;
            ST_MUL:      cmd.op = OP_MUL;
            ST_ADD:      cmd.op = OP_ADD;
            ST_DONE:     cmd.out_load = out_free;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DISPATCH))
        else $error("accepted item did not start work");
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");
    a_load_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (state_reg == ST_DONE && (!out_valid_reg || !out_stall)))
        else $error("result overwritten while pending");
`endif

endmodule

### hw/rtl/kti_dp.sv
// Datapath: key store, bracket search, fraction divider and component blend.
module kti_dp
    import kti_pkg::*;
#(
    parameter int KEY_DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 st,
    input  logic                     in_cmd,
    input  logic [TIME_W-1:0]        in_time,
    input  logic [NCOMP-1:0][COMP_W-1:0] in_comp,
    output logic [1:0]               out_status,
    output logic [NCOMP-1:0][COMP_W-1:0] out_res
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CW = $clog2(KEY_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(KEY_DEPTH);

    key_row_t                     mem [KEY_DEPTH];
    key_row_t                     rd_reg;
    key_row_t                     in_row_reg;
    key_row_t                     a_reg;
    key_row_t                     b_reg;
    logic                         cmd_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                rd_addr;
    logic                         rd_en;
    logic [TIME_W:0]              rem_reg;
    logic [TIME_W-1:0]            dur_reg;
    logic [FRAC_W-1:0]            q_reg;
    logic [DIV_CNT_W-1:0]         div_cnt_reg;
    logic [K_W-1:0]               k_reg;
    logic signed [50:0]           prod_reg;
    logic [1:0]                   wk_status_reg;
    logic [NCOMP-1:0][COMP_W-1:0] wk_res_reg;
    logic [1:0]                   out_status_reg;
    logic [NCOMP-1:0][COMP_W-1:0] out_res_reg;

    logic                         div_ge;
    logic [TIME_W-1:0]            div_r1;
    logic [FRAC_W-1:0]            frac;
    logic signed [32:0]           diff;
    logic signed [17:0]           frac_s;
    logic [COMP_W-1:0]            ca;
    logic [COMP_W-1:0]            cb;

    assign st.is_insert = (cmd_reg == CMD_INSERT);
    assign st.full      = (count_reg == FULL_CNT);
    assign st.empty     = (count_reg == '0);
    assign st.idx_one   = (idx_reg == CW'(1));
    assign st.t_le_rd   = (in_row_reg.tm <= rd_reg.tm);
    assign st.t_ge_rd   = (in_row_reg.tm >= rd_reg.tm);
    assign st.div_last  = (div_cnt_reg == DIV_LAST);
    assign st.comp_last = (k_reg == K_LAST);

    assign out_status = out_status_reg;
    assign out_res    = out_res_reg;

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = idx_reg;
        case (cmd.op)
            OP_INS_RD:   rd_addr = idx_reg - CW'(1);
            OP_RD_FIRST: rd_addr = '0;
            OP_RD_LAST:  rd_addr = count_reg - CW'(1);
            OP_RD_IDX:   rd_addr = idx_reg;
            OP_NEXT_IDX: rd_addr = idx_reg + CW'(1);
            default:     rd_en   = 1'b0;
        endcase
    end

    assign div_ge = (rem_reg >= {1'b0, dur_reg});
    assign div_r1 = div_ge ? TIME_W'(rem_reg - {1'b0, dur_reg}) : rem_reg[TIME_W-1:0];
    assign frac   = (dur_reg == '0) ? '0 : q_reg;
    assign ca     = a_reg.comp[k_reg];
    assign cb     = b_reg.comp[k_reg];
    assign diff   = $signed({cb[COMP_W-1], cb}) - $signed({ca[COMP_W-1], ca});
    assign frac_s = $signed({1'b0, frac});

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_INS_SHIFT)
            mem[idx_reg[AW-1:0]] <= rd_reg;
        else if (cmd.op == OP_INS_WR)
            mem[idx_reg[AW-1:0]] <= in_row_reg;
        if (rd_en)
            rd_reg <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.op == OP_INS_WR)
            count_reg <= count_reg + CW'(1);
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                cmd_reg         <= in_cmd;
                in_row_reg.tm   <= in_time;
                in_row_reg.comp <= in_comp;
                idx_reg         <= count_reg;
            end
            OP_DROP:
            begin
                wk_status_reg <= STAT_DROPPED;
                wk_res_reg    <= '0;
            end
            OP_EMPTY:
            begin
                wk_status_reg <= STAT_EMPTY;
                wk_res_reg    <= {{3{ONE_Q16}}, {((NCOMP - 3) * COMP_W){1'b0}}};
            end
            OP_INS_SHIFT: idx_reg <= idx_reg - CW'(1);
            OP_INS_WR:
            begin
                wk_status_reg <= STAT_INSERTED;
                wk_res_reg    <= '0;
            end
            OP_TAKE_ROW:
            begin
                wk_status_reg <= STAT_SAMPLED;
                wk_res_reg    <= rd_reg.comp;
            end
            OP_RD_LAST:
            begin
                a_reg   <= rd_reg;
                idx_reg <= CW'(1);
            end
            OP_NEXT_IDX:
            begin
                a_reg   <= rd_reg;
                idx_reg <= idx_reg + CW'(1);
            end
            OP_DIV_INIT:
            begin
                b_reg         <= rd_reg;
                rem_reg       <= {1'b0, in_row_reg.tm - a_reg.tm};
                dur_reg       <= rd_reg.tm - a_reg.tm;
                q_reg         <= '0;
                div_cnt_reg   <= '0;
                k_reg         <= '0;
                wk_status_reg <= STAT_SAMPLED;
            end
            OP_DIV_STEP:
            begin
                rem_reg     <= {div_r1, 1'b0};
                q_reg       <= {q_reg[FRAC_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            OP_MUL: prod_reg <= diff * frac_s;
            OP_ADD:
            begin
                wk_res_reg[k_reg] <= ca + prod_reg[47:16];
                k_reg             <= k_reg + K_W'(1);
            end
            default: ;
        endcase
        if (cmd.out_load)
        begin
            out_status_reg <= wk_status_reg;
            out_res_reg    <= wk_res_reg;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("key count beyond depth");
    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INS_WR) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow track");
    a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INS_WR) |-> (count_reg != FULL_CNT))
        else $error("write into full store");
`endif

endmodule
